// File: rtl/sng_pkg.sv
// Package for the sparse neuron graph evaluator.
// Holds sizes, item kind codes and the activation table builder.
// Used by rtl/sparse_neuron_graph_eval.sv; depends on nothing else.
package sng_pkg;

    localparam int MAX_GENES       = 256;
    localparam int NEURON_IDS      = 256;
    localparam int OUTPUTS         = 2;
    localparam int SIGMOID_ENTRIES = 2048;

    localparam int GA_W   = $clog2(MAX_GENES);
    localparam int CNT_W  = $clog2(MAX_GENES + 1);
    localparam int NID_W  = $clog2(NEURON_IDS);
    localparam int SIG_W  = $clog2(SIGMOID_ENTRIES);
    localparam int IDX_SH = 26 - SIG_W;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_LOAD  = 2'd1;
    localparam logic [1:0] KIND_EVAL  = 2'd2;

    localparam logic [7:0] OUTPUT_BASE_RESET = 8'd128;

    localparam longint FX_ONE = 64'sd1073741824;
    localparam longint S_STEP = (64'sd210453397504 + 5 * SIGMOID_ENTRIES)
                                / (10 * SIGMOID_ENTRIES);

    typedef logic [12:0] act_val_t;
    typedef act_val_t act_rom_t [SIGMOID_ENTRIES];

    function automatic act_rom_t build_act_rom();
        act_rom_t r;
        longint s2;
        longint s3;
        longint s4;
        longint s5;
        longint q;
        longint p;
        longint num;
        longint den;
        longint dsh;
        act_val_t quo;
        s2 = (S_STEP * S_STEP) >>> 30;
        s3 = (s2 * S_STEP) >>> 30;
        s4 = (s3 * S_STEP) >>> 30;
        s5 = (s4 * S_STEP) >>> 30;
        q  = FX_ONE - S_STEP + s2 / 2 - s3 / 6 + s4 / 24 - s5 / 120;
        p  = FX_ONE;
        for (int i = 0; i < SIGMOID_ENTRIES; i++)
        begin
            if (i > 0)
            begin
                p = (p * q + 64'sd536870912) >>> 30;
            end
            num = (FX_ONE - p) * 8192 + (FX_ONE + p);
            den = 2 * (FX_ONE + p);
            quo = '0;
            for (int b = 12; b >= 0; b--)
            begin
                dsh = den <<< b;
                if (num >= dsh)
                begin
                    num    = num - dsh;
                    quo[b] = 1'b1;
                end
            end
            r[i] = quo;
        end
        return r;
    endfunction

endpackage

// File: rtl/sparse_neuron_graph_eval.sv
// Sparse neuron graph evaluator. An evaluate writes the input and bias neurons, then for each
// neuron id that some gene targets scans the gene table, squashes the sum and writes it, and
// then reads and loads each output; clear and load are done in the idle state. The input stalls until
// the last output is loaded, and the gene scan reads one gene per cycle to the accumulator.
// Reset (rst_n low, asynchronous) empties the gene table, zeroes all neuron
// values through valid bits and sets output_base to 128.
module sparse_neuron_graph_eval
    import sng_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [7:0]         cfg_write_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [7:0]         gene_source,
    input  logic [7:0]         gene_target,
    input  logic signed [15:0] gene_weight,
    input  logic               gene_enabled,
    input  logic signed [11:0] ball_paddle_dx,
    input  logic signed [11:0] ball_speed_x,
    input  logic signed [11:0] ball_speed_y,
    input  logic signed [11:0] ball_y,
    input  logic signed [11:0] paddle_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         output_index,
    output logic signed [13:0] output_value,
    output logic               last_output,
    output logic               genes_overflowed
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b00000001,
        ST_INIT   = 8'b00000010,
        ST_NEXT   = 8'b00000100,
        ST_SCAN   = 8'b00001000,
        ST_ACT    = 8'b00010000,
        ST_WRITE  = 8'b00100000,
        ST_OUT_RD = 8'b01000000,
        ST_OUT_LD = 8'b10000000
    } state_t;

    localparam act_rom_t ACT_ROM = build_act_rom();
    localparam logic [CNT_W-1:0] GENES_FULL = CNT_W'(MAX_GENES);
    localparam logic [NID_W-1:0] LAST_ID = NID_W'(NEURON_IDS - 1);
    localparam logic [2:0] LAST_OUT = 3'(OUTPUTS - 1);

    state_t state_reg;
    logic [7:0] output_base_reg;
    logic [CNT_W-1:0] gene_count_reg;
    logic overflow_reg;
    logic [NEURON_IDS-1:0] hit_reg;
    logic [NEURON_IDS-1:0] nv_valid_reg;

    logic [31:0] gene_mem [MAX_GENES];
    logic [23:0] nv_mem [NEURON_IDS];

    logic [11:0] in_val_reg [5];
    logic [2:0] init_cnt_reg;
    logic [NID_W-1:0] id_reg;
    logic [CNT_W-1:0] g_reg;
    logic [2:0] o_reg;

    logic [31:0] gene_q_reg;
    logic s1_v_reg;
    logic s2_v_reg;
    logic s3_v_reg;
    logic [23:0] nv_q_reg;
    logic nv_q_valid_reg;
    logic signed [15:0] w_reg;
    logic signed [39:0] prod_reg;
    logic signed [47:0] sum_reg;
    act_val_t rom_q_reg;
    logic act_neg_reg;
    logic act_big_reg;

    logic out_valid_reg;
    logic [2:0] out_index_reg;
    logic signed [13:0] out_value_reg;
    logic out_last_reg;
    logic out_ovf_reg;

    logic accept;
    logic issue;
    logic match;
    logic nv_rd_en;
    logic [NID_W-1:0] nv_rd_addr;
    logic nv_we;
    logic [NID_W-1:0] nv_wr_addr;
    logic [23:0] nv_wr_data;
    logic signed [23:0] src_val;
    logic signed [48:0] sum_ext;
    logic signed [47:0] sum_next;
    logic [47:0] mag;
    logic signed [23:0] act_val;
    logic out_free;
    logic out_load;
    logic signed [23:0] sat_in;
    logic signed [13:0] sat_val;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign issue    = (state_reg == ST_SCAN) && (g_reg < gene_count_reg);
    assign match    = (NID_W'(gene_q_reg[15:8]) == id_reg);
    assign nv_rd_en = s1_v_reg || (state_reg == ST_OUT_RD);
    assign nv_rd_addr = (state_reg == ST_OUT_RD) ? NID_W'(output_base_reg + {5'd0, o_reg})
                                                 : NID_W'(gene_q_reg[7:0]);
    assign src_val  = nv_q_valid_reg ? $signed(nv_q_reg) : 24'sd0;
    assign sum_ext  = {sum_reg[47], sum_reg} + 49'(prod_reg);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == ST_OUT_LD) && out_free;

    always_comb
    begin
        if (sum_ext[48] != sum_ext[47])
        begin
            sum_next = sum_ext[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end
        else
        begin
            sum_next = sum_ext[47:0];
        end
    end

    assign mag = sum_reg[47] ? 48'(-sum_reg) : sum_reg;
    assign act_val = act_neg_reg ? -24'(act_big_reg ? 13'd4096 : rom_q_reg)
                                 :  24'(act_big_reg ? 13'd4096 : rom_q_reg);

    always_comb
    begin
        nv_we      = 1'b0;
        nv_wr_addr = id_reg;
        nv_wr_data = act_val;
        if (state_reg == ST_INIT)
        begin
            nv_we      = 1'b1;
            nv_wr_addr = NID_W'(init_cnt_reg);
            nv_wr_data = (init_cnt_reg == 3'd5) ? 24'd4096
                                                : {in_val_reg[init_cnt_reg], 12'd0};
        end
        else if (state_reg == ST_WRITE)
        begin
            nv_we = 1'b1;
        end
    end

    assign sat_in  = src_val;
    assign sat_val = (sat_in > 24'sd4096) ? 14'sd4096 :
                     (sat_in < -24'sd4096) ? -14'sd4096 : sat_in[13:0];

    always_ff @(posedge clk)
    begin
        if (accept && kind == KIND_LOAD && gene_enabled && gene_count_reg < GENES_FULL)
        begin
            gene_mem[gene_count_reg[GA_W-1:0]] <= {gene_weight, gene_target, gene_source};
        end
        if (issue)
        begin
            gene_q_reg <= gene_mem[g_reg[GA_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (nv_we)
        begin
            nv_mem[nv_wr_addr] <= nv_wr_data;
        end
        if (nv_rd_en)
        begin
            nv_q_reg <= nv_mem[nv_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_val_reg[0] <= ball_paddle_dx;
            in_val_reg[1] <= ball_speed_x;
            in_val_reg[2] <= ball_speed_y;
            in_val_reg[3] <= ball_y;
            in_val_reg[4] <= paddle_y;
        end
        if (s1_v_reg)
        begin
            w_reg <= gene_q_reg[31:16];
        end
        if (s2_v_reg)
        begin
            prod_reg <= w_reg * src_val;
        end
        if (state_reg == ST_NEXT)
        begin
            sum_reg <= '0;
        end
        else if (s3_v_reg)
        begin
            sum_reg <= sum_next;
        end
        if (state_reg == ST_ACT)
        begin
            rom_q_reg   <= ACT_ROM[mag[25:IDX_SH]];
            act_neg_reg <= sum_reg[47];
            act_big_reg <= |mag[47:26];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            output_base_reg <= OUTPUT_BASE_RESET;
            gene_count_reg  <= '0;
            overflow_reg    <= 1'b0;
            hit_reg         <= '0;
            nv_valid_reg    <= '0;
            init_cnt_reg    <= '0;
            id_reg          <= '0;
            g_reg           <= '0;
            o_reg           <= '0;
            s1_v_reg        <= 1'b0;
            s2_v_reg        <= 1'b0;
            s3_v_reg        <= 1'b0;
            nv_q_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_index_reg   <= '0;
            out_value_reg   <= '0;
            out_last_reg    <= 1'b0;
            out_ovf_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                output_base_reg <= cfg_write_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (nv_we)
            begin
                nv_valid_reg[nv_wr_addr] <= 1'b1;
            end
            if (nv_rd_en)
            begin
                nv_q_valid_reg <= nv_valid_reg[nv_rd_addr];
            end
            s1_v_reg <= issue;
            s2_v_reg <= s1_v_reg && match;
            s3_v_reg <= s2_v_reg;
            if (issue)
            begin
                g_reg <= g_reg + 1'b1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (kind)
                            KIND_CLEAR:
                            begin
                                gene_count_reg <= '0;
                                overflow_reg   <= 1'b0;
                                hit_reg        <= '0;
                                nv_valid_reg   <= '0;
                            end
                            KIND_LOAD:
                            begin
                                if (gene_enabled)
                                begin
                                    if (gene_count_reg < GENES_FULL)
                                    begin
                                        gene_count_reg <= gene_count_reg + 1'b1;
                                        hit_reg[NID_W'(gene_target)] <= 1'b1;
                                    end
                                    else
                                    begin
                                        overflow_reg <= 1'b1;
                                    end
                                end
                            end
                            KIND_EVAL:
                            begin
                                init_cnt_reg <= '0;
                                state_reg    <= ST_INIT;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_INIT:
                begin
                    init_cnt_reg <= init_cnt_reg + 1'b1;
                    if (init_cnt_reg == 3'd5)
                    begin
                        id_reg    <= '0;
                        state_reg <= ST_NEXT;
                    end
                end
                ST_NEXT:
                begin
                    g_reg <= '0;
                    if (hit_reg[id_reg])
                    begin
                        state_reg <= ST_SCAN;
                    end
                    else if (id_reg == LAST_ID)
                    begin
                        o_reg     <= '0;
                        state_reg <= ST_OUT_RD;
                    end
                    else
                    begin
                        id_reg <= id_reg + 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (!issue && !s1_v_reg && !s2_v_reg && !s3_v_reg)
                    begin
                        state_reg <= ST_ACT;
                    end
                end
                ST_ACT:
                begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    if (id_reg == LAST_ID)
                    begin
                        o_reg     <= '0;
                        state_reg <= ST_OUT_RD;
                    end
                    else
                    begin
                        id_reg    <= id_reg + 1'b1;
                        state_reg <= ST_NEXT;
                    end
                end
                ST_OUT_RD:
                begin
                    state_reg <= ST_OUT_LD;
                end
                ST_OUT_LD:
                begin
                    if (out_free)
                    begin
                        out_index_reg <= o_reg;
                        out_value_reg <= sat_val;
                        out_last_reg  <= (o_reg == LAST_OUT);
                        out_ovf_reg   <= overflow_reg;
                        if (o_reg == LAST_OUT)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            o_reg     <= o_reg + 1'b1;
                            state_reg <= ST_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign output_index     = out_index_reg;
    assign output_value     = out_value_reg;
    assign last_output      = out_last_reg;
    assign genes_overflowed = out_ovf_reg;

    assert property (@(posedge clk) disable iff (!rst_n) gene_count_reg <= GENES_FULL)
        else $error("gene count beyond table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_output |-> output_index == LAST_OUT)
        else $error("last output flag on wrong index");

    assert property (@(posedge clk) disable iff (!rst_n)
        s3_v_reg |-> state_reg == ST_SCAN)
        else $error("accumulate outside gene scan");

endmodule

// File: tb/sv/sparse_neuron_graph_eval_test.sv
// Self-checking testbench for sparse_neuron_graph_eval.
// Drives clear, gene load, evaluate and unknown-kind transfers under random idling and
// output stalls and checks every result against an in-bench predictor. Depends on rtl/sng_pkg.sv and the RTL.
`timescale 1ns / 1ps

module sparse_neuron_graph_eval_test
    import sng_pkg::*;
;

    typedef struct {
        logic [1:0]         kind;
        logic [7:0]         src;
        logic [7:0]         tgt;
        logic signed [15:0] weight;
        logic               enabled;
        logic signed [11:0] game [5];
    } net_item_t;

    typedef struct {
        logic [2:0]         index;
        logic signed [13:0] value;
        logic               last;
        logic               ovf;
    } out_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write_en = 1'b0;
    logic [7:0]         cfg_write_data = 8'd0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         kind = KIND_CLEAR;
    logic [7:0]         gene_source = 8'd0;
    logic [7:0]         gene_target = 8'd0;
    logic signed [15:0] gene_weight = 16'sd0;
    logic               gene_enabled = 1'b0;
    logic signed [11:0] ball_paddle_dx = 12'sd0;
    logic signed [11:0] ball_speed_x = 12'sd0;
    logic signed [11:0] ball_speed_y = 12'sd0;
    logic signed [11:0] ball_y = 12'sd0;
    logic signed [11:0] paddle_y = 12'sd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [2:0]         output_index;
    logic signed [13:0] output_value;
    logic               last_output;
    logic               genes_overflowed;

    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    localparam int WATCHDOG_LIMIT = 300000;

    net_item_t pending_items [$];
    out_item_t expected_outputs [$];

    logic [7:0]         gene_src_mem [MAX_GENES];
    logic [7:0]         gene_tgt_mem [MAX_GENES];
    logic signed [15:0] gene_w_mem [MAX_GENES];
    int                 stored_genes = 0;
    int                 neuron_state [NEURON_IDS];
    logic               overflow_seen = 1'b0;
    logic [7:0]         output_base_id = OUTPUT_BASE_RESET;
    int                 tanh_rom [SIGMOID_ENTRIES];

    int  mismatch_count = 0;
    int  items_sent = 0;
    int  evals_sent = 0;
    int  outputs_checked = 0;
    int  idle_cycles = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    bit  calm_mode = 1'b0;
    int  planned_genes = 0;

    sparse_neuron_graph_eval uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .gene_source(gene_source),
        .gene_target(gene_target),
        .gene_weight(gene_weight),
        .gene_enabled(gene_enabled),
        .ball_paddle_dx(ball_paddle_dx),
        .ball_speed_x(ball_speed_x),
        .ball_speed_y(ball_speed_y),
        .ball_y(ball_y),
        .paddle_y(paddle_y),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .output_index(output_index),
        .output_value(output_value),
        .last_output(last_output),
        .genes_overflowed(genes_overflowed)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void build_tanh_rom();
        longint one;
        longint s;
        longint s2;
        longint s3;
        longint s4;
        longint s5;
        longint q;
        longint p;
        one = 64'sd1 << 30;
        s   = (64'sd196 * one + 5 * SIGMOID_ENTRIES) / (10 * SIGMOID_ENTRIES);
        s2  = (s * s) >>> 30;
        s3  = (s2 * s) >>> 30;
        s4  = (s3 * s) >>> 30;
        s5  = (s4 * s) >>> 30;
        q   = one - s + s2 / 2 - s3 / 6 + s4 / 24 - s5 / 120;
        p   = one;
        for (int i = 0; i < SIGMOID_ENTRIES; i++)
        begin
            if (i > 0)
            begin
                p = (p * q + (64'sd1 << 29)) >>> 30;
            end
            tanh_rom[i] = int'(((one - p) * 8192 + (one + p)) / (2 * (one + p)));
        end
    endfunction

    function automatic int squash(longint acc);
        longint mag;
        longint slot;
        int     r;
        mag  = (acc < 0) ? -acc : acc;
        slot = mag >>> 15;
        r    = (slot >= SIGMOID_ENTRIES) ? 4096 : tanh_rom[slot];
        return (acc < 0) ? -r : r;
    endfunction

    function automatic void predict_network(net_item_t it);
        longint    acc;
        bit        hit;
        int        v;
        out_item_t o;
        case (it.kind)
            KIND_CLEAR:
            begin
                stored_genes  = 0;
                overflow_seen = 1'b0;
                foreach (neuron_state[i]) neuron_state[i] = 0;
            end
            KIND_LOAD:
            begin
                if (it.enabled)
                begin
                    if (stored_genes >= MAX_GENES)
                    begin
                        overflow_seen = 1'b1;
                    end
                    else
                    begin
                        gene_src_mem[stored_genes] = it.src;
                        gene_tgt_mem[stored_genes] = it.tgt;
                        gene_w_mem[stored_genes]   = it.weight;
                        stored_genes++;
                    end
                end
            end
            KIND_EVAL:
            begin
                for (int i = 0; i < 5; i++) neuron_state[i] = int'(it.game[i]) * 4096;
                neuron_state[5] = 4096;
                for (int id = 0; id < NEURON_IDS; id++)
                begin
                    hit = 1'b0;
                    acc = 0;
                    for (int g = 0; g < stored_genes; g++)
                    begin
                        if (gene_tgt_mem[g] == id)
                        begin
                            hit = 1'b1;
                            acc += longint'(gene_w_mem[g]) * neuron_state[gene_src_mem[g]];
                            if (acc > (64'sd1 << 47) - 1) acc = (64'sd1 << 47) - 1;
                            if (acc < -(64'sd1 << 47)) acc = -(64'sd1 << 47);
                        end
                    end
                    if (hit) neuron_state[id] = squash(acc);
                end
                for (int i = 0; i < OUTPUTS; i++)
                begin
                    v = neuron_state[(int'(output_base_id) + i) % NEURON_IDS];
                    if (v > 4096) v = 4096;
                    if (v < -4096) v = -4096;
                    o.index = i[2:0];
                    o.value = v[13:0];
                    o.last  = (i == OUTPUTS - 1);
                    o.ovf   = overflow_seen;
                    expected_outputs = {expected_outputs, o};
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_mode || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_network(pending_items[0]);
                pending_items.pop_front();
                items_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0 || pending_items.size() == 0
                    || (in_valid && pending_items.size() == 0))
                begin
                    if (gap_left > 0) gap_left--;
                    in_valid <= 1'b0;
                end
                else if (in_valid && !in_stall && pending_items.size() > 0 && gap_left == 0)
                begin
                    in_valid       <= 1'b1;
                    kind           <= pending_items[0].kind;
                    gene_source    <= pending_items[0].src;
                    gene_target    <= pending_items[0].tgt;
                    gene_weight    <= pending_items[0].weight;
                    gene_enabled   <= pending_items[0].enabled;
                    ball_paddle_dx <= pending_items[0].game[0];
                    ball_speed_x   <= pending_items[0].game[1];
                    ball_speed_y   <= pending_items[0].game[2];
                    ball_y         <= pending_items[0].game[3];
                    paddle_y       <= pending_items[0].game[4];
                    gap_left       = pick_gap();
                end
                else
                begin
                    in_valid       <= 1'b1;
                    kind           <= pending_items[0].kind;
                    gene_source    <= pending_items[0].src;
                    gene_target    <= pending_items[0].tgt;
                    gene_weight    <= pending_items[0].weight;
                    gene_enabled   <= pending_items[0].enabled;
                    ball_paddle_dx <= pending_items[0].game[0];
                    ball_speed_x   <= pending_items[0].game[1];
                    ball_speed_y   <= pending_items[0].game[2];
                    ball_y         <= pending_items[0].game[3];
                    paddle_y       <= pending_items[0].game[4];
                    gap_left       = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                outputs_checked++;
                if (expected_outputs.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected output: index %0d value %0d", output_index,
                                 output_value);
                end
                else
                begin
                    if (output_index !== expected_outputs[0].index
                        || output_value !== expected_outputs[0].value
                        || last_output !== expected_outputs[0].last
                        || genes_overflowed !== expected_outputs[0].ovf)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Output mismatch: expected idx %0d val %0d last %0b",
                                     expected_outputs[0].index, expected_outputs[0].value,
                                     expected_outputs[0].last,
                                     " ovf %0b, got idx %0d val %0d last %0b ovf %0b",
                                     expected_outputs[0].ovf,
                                     output_index, output_value, last_output,
                                     genes_overflowed);
                    end
                    expected_outputs.pop_front();
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall <= (stall_left > 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic net_item_t blank_item(logic [1:0] k);
        net_item_t it;
        it.kind    = k;
        it.src     = 8'($urandom);
        it.tgt     = 8'($urandom);
        it.weight  = 16'($urandom);
        it.enabled = 1'($urandom);
        foreach (it.game[i]) it.game[i] = 12'($urandom);
        return it;
    endfunction

    function automatic void queue_item(net_item_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic void push_load(int src, int tgt, int w, bit en);
        net_item_t it;
        it         = blank_item(KIND_LOAD);
        it.src     = src[7:0];
        it.tgt     = tgt[7:0];
        it.weight  = w[15:0];
        it.enabled = en;
        if (en) planned_genes++;
        queue_item(it);
    endfunction

    function automatic void push_eval(int fill);
        net_item_t it;
        it = blank_item(KIND_EVAL);
        if (fill != 0)
        begin
            foreach (it.game[i]) it.game[i] = fill[11:0];
        end
        evals_sent++;
        queue_item(it);
    endfunction

    function automatic void push_clear();
        planned_genes = 0;
        queue_item(blank_item(KIND_CLEAR));
    endfunction

    function automatic int pick_neuron(logic [7:0] base);
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 5);
            1: return base;
            2: return base + 1;
            3: return $urandom_range(0, 255);
            default: return $urandom_range(6, 14);
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_outputs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_base(logic [7:0] v);
        wait_idle();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        output_base_id = v;
    endtask

    initial
    begin
        logic [7:0] base;
        build_tanh_rom();
        foreach (neuron_state[i]) neuron_state[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_base(OUTPUT_BASE_RESET);
        push_eval(0);
        queue_item(blank_item(KIND_UNKNOWN));
        push_load(5, 128, 32767, 1'b0);
        push_load(5, 128, 32767, 1'b1);
        push_load(0, 129, -32768, 1'b1);
        push_load(5, 0, 16384, 1'b1);
        push_load(255, 255, 4096, 1'b1);
        push_load(128, 129, 12000, 1'b1);
        push_load(0, 128, 0, 1'b1);
        push_eval(-2048);
        push_eval(2047);
        push_eval(1);
        push_clear();
        push_eval(0);

        write_base(8'd6);
        push_load(1, 6, 32767, 1'b1);
        push_load(2, 7, -32768, 1'b1);
        push_eval(0);
        for (int i = 0; i < 24; i++)
            push_load($urandom_range(0, 7), 6 + (i % 2), $urandom, 1'b1);
        push_eval(0);
        push_eval(-2048);
        push_clear();
        push_eval(0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: base = 8'd248;
                1: base = 8'd6;
                default: base = $urandom_range(6, 248);
            endcase
            write_base(base);
            calm_mode = (phase == 2);
            push_clear();
            while (evals_sent < 9 + (phase + 1) * 6)
            begin
                if (planned_genes > 40 || $urandom_range(0, 3) == 0) push_clear();
                repeat ($urandom_range(1, 8))
                    push_load(pick_neuron(base), pick_neuron(base), $urandom,
                              $urandom_range(0, 7) != 0);
                if ($urandom_range(0, 5) == 0)
                    queue_item(blank_item(KIND_UNKNOWN));
                repeat ($urandom_range(1, 2)) push_eval(0);
            end
        end

        wait_idle();
        $display("Sent %0d transfers including %0d evaluations; checked %0d outputs.",
                 items_sent, evals_sent, outputs_checked);
        $display("Covered output bases 6, 128 and 248, recurrent genes and ignored items.");
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Mismatches: %0d", mismatch_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
